[rtl/jpeg_carver_byte_scanner_macros.svh]
// Assertion macros shared by the byte scanner RTL.
// Uses the i_clk and i_rst_n names of the including module.
`ifndef JPEG_CARVER_BYTE_SCANNER_MACROS_SVH
`define JPEG_CARVER_BYTE_SCANNER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define JCBS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jcbs assertion failed");
// next-cycle implication
`define JCBS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jcbs assertion failed");
`else
`define JCBS_ASSERT_IMP(label, ante, cons)
`define JCBS_ASSERT_NXT(label, ante, cons)
`endif
`endif

[rtl/jcbs_pkg.sv]
// Types and byte constants for the JPEG carver byte scanner.
// No dependencies.
`timescale 1ns / 1ps
package jcbs_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in;

    typedef struct packed {
        logic [31:0] name_first;
        logic [31:0] name_last;
        logic [31:0] image_first;
        logic [31:0] image_last;
        logic        offset_saturated;
    } t_out;

    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_MARK   = 8'hFF;
    localparam logic [7:0] C_SOI    = 8'hD8;
    localparam logic [7:0] C_EOI    = 8'hD9;
    localparam logic [7:0] C_J_UP   = 8'h4A;
    localparam logic [7:0] C_J_LO   = 8'h6A;
    localparam logic [7:0] C_P_UP   = 8'h50;
    localparam logic [7:0] C_P_LO   = 8'h70;
    localparam logic [7:0] C_G_UP   = 8'h47;
    localparam logic [7:0] C_G_LO   = 8'h67;

endpackage

[rtl/jcbs_scan.sv]
// Scan state and next-state logic: offsets, recent bytes, marker phases.
// Depends on jcbs_pkg and the jcbs assertion macros.
`timescale 1ns / 1ps
`include "jpeg_carver_byte_scanner_macros.svh"
module jcbs_scan #(
    parameter int OFFSET_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  jcbs_pkg::t_in i_beat,
    output logic          o_res_valid,
    output jcbs_pkg::t_out o_res
);
    import jcbs_pkg::*;

    typedef enum logic [1:0] {
        PH_NAME  = 2'd0,
        PH_START = 2'd1,
        PH_END   = 2'd2
    } t_phase;

    logic [15:0]            r_recent,      n_recent;
    t_phase                 r_phase,       n_phase;
    logic [OFFSET_BITS-1:0] r_offset,      n_offset;
    logic [OFFSET_BITS-1:0] r_after_nul,   n_after_nul;
    logic [OFFSET_BITS-1:0] r_name_first,  n_name_first;
    logic [OFFSET_BITS-1:0] r_name_last,   n_name_last;
    logic [OFFSET_BITS-1:0] r_image_first, n_image_first;
    logic                   r_sat,         n_sat;

    // state as seen by this beat; file_start wipes it first
    logic [15:0]            e_recent;
    t_phase                 e_phase;
    logic [OFFSET_BITS-1:0] e_offset, e_after_nul, e_name_first, e_name_last, e_image_first;
    logic                   e_sat;
    logic [7:0]             older, prev, b;
    logic                   at_max;
    logic                   over;

    function automatic logic ovf32(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS-1:0] hi;
        hi = v >> 32;
        return |hi;
    endfunction

    function automatic logic [31:0] clamp32(input logic [OFFSET_BITS-1:0] v);
        return ovf32(v) ? 32'hFFFF_FFFF : 32'(v);
    endfunction

    always_comb begin
        if (i_beat.file_start) begin
            e_recent      = '0;
            e_phase       = PH_NAME;
            e_offset      = '0;
            e_after_nul   = '0;
            e_name_first  = '0;
            e_name_last   = '0;
            e_image_first = '0;
            e_sat         = 1'b0;
        end else begin
            e_recent      = r_recent;
            e_phase       = r_phase;
            e_offset      = r_offset;
            e_after_nul   = r_after_nul;
            e_name_first  = r_name_first;
            e_name_last   = r_name_last;
            e_image_first = r_image_first;
            e_sat         = r_sat;
        end

        older  = e_recent[15:8];
        prev   = e_recent[7:0];
        b      = i_beat.data_byte;
        at_max = &e_offset;

        n_offset = at_max ? e_offset : e_offset + OFFSET_BITS'(1);
        n_sat    = e_sat | at_max;

        n_phase       = e_phase;
        n_name_first  = e_name_first;
        n_name_last   = e_name_last;
        n_image_first = e_image_first;
        o_res_valid   = 1'b0;

        case (e_phase)
            PH_START: begin
                if (older == C_MARK && prev == C_SOI && b == C_MARK) begin
                    n_image_first = (e_offset >= OFFSET_BITS'(2)) ?
                                    e_offset - OFFSET_BITS'(2) : '0;
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                if (prev == C_MARK && b == C_EOI) begin
                    o_res_valid = 1'b1;
                    n_phase     = PH_NAME;
                end
            end
            default: begin
                // case-insensitive "JPG" ending on this byte
                if ((b == C_G_UP || b == C_G_LO) && (prev == C_P_UP || prev == C_P_LO) &&
                    (older == C_J_UP || older == C_J_LO)) begin
                    n_name_first = e_after_nul;
                    n_name_last  = e_offset;
                    n_phase      = PH_START;
                end
            end
        endcase

        // offset after a NUL tracks the saturating counter
        n_after_nul = (b == C_NUL) ? n_offset : e_after_nul;
        n_recent    = {prev, b};

        over = n_sat | ovf32(e_name_first) | ovf32(e_name_last) |
               ovf32(e_image_first) | ovf32(e_offset);
        o_res.name_first       = clamp32(e_name_first);
        o_res.name_last        = clamp32(e_name_last);
        o_res.image_first      = clamp32(e_image_first);
        o_res.image_last       = clamp32(e_offset);
        o_res.offset_saturated = over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent      <= '0;
            r_phase       <= PH_NAME;
            r_offset      <= '0;
            r_after_nul   <= '0;
            r_name_first  <= '0;
            r_name_last   <= '0;
            r_image_first <= '0;
            r_sat         <= 1'b0;
        end else if (i_fire) begin
            r_recent      <= n_recent;
            r_phase       <= n_phase;
            r_offset      <= n_offset;
            r_after_nul   <= n_after_nul;
            r_name_first  <= n_name_first;
            r_name_last   <= n_name_last;
            r_image_first <= n_image_first;
            r_sat         <= n_sat;
        end
    end

    `JCBS_ASSERT_IMP(a_sat_pinned, r_sat, &r_offset)
    `JCBS_ASSERT_NXT(a_res_rearm, i_fire && o_res_valid, r_phase == PH_NAME)
    `JCBS_ASSERT_NXT(a_res_on_eoi, i_fire && o_res_valid, r_recent == {C_MARK, C_EOI})

endmodule

[rtl/jpeg_carver_byte_scanner.sv]
// JPEG carver byte scanner, top level: input register, scan core, result register.
// Depends on jcbs_pkg, jcbs_scan and the jcbs assertion macros.
//
// Takes a container file one byte per beat and reports, on each FF D9 that closes an
// image, the name span ending in "JPG" and the image span from FF D8 FF to D9.
// Throughput is one byte per cycle while the result side does not stall; a result
// passes the input register, then the result register, after its byte is accepted;
// the scan core does the compare, phase update and offset increment between them.
`timescale 1ns / 1ps
`include "jpeg_carver_byte_scanner_macros.svh"
module jpeg_carver_byte_scanner #(
    parameter int OFFSET_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  jcbs_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output jcbs_pkg::t_out o_data
);
    import jcbs_pkg::*;

    logic   r_in_valid;
    t_in    r_in;
    logic   r_out_valid;
    t_out   r_out;
    logic   proc;
    logic   take;
    logic   res_valid;
    t_out   res;

    // result slot is free if empty or draining this cycle
    assign proc    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !proc;
    assign take    = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    jcbs_scan #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (proc),
        .i_beat      (r_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= res_valid;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_data;
        end
        if (proc && res_valid) begin
            r_out <= res;
        end
    end

    `JCBS_ASSERT_NXT(a_res_lands, proc && res_valid, o_valid)
    `JCBS_ASSERT_NXT(a_out_drains, o_valid && !i_stall && !(proc && res_valid), !o_valid)

endmodule

[tb/jpeg_carver_byte_scanner_check.sv]
`timescale 1ns / 1ps
// Scoreboard for the JPEG carver byte scanner: follows every accepted byte, predicts
// the carved name and image spans, and checks each reported span against them.
// Depends on jcbs_pkg.
module jpeg_carver_byte_scanner_check #(
    parameter int OFFSET_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  jcbs_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  jcbs_pkg::t_out i_out_data,
    output int             o_mismatches,
    output int             o_pending
);
    import jcbs_pkg::*;

    typedef enum logic [1:0] {SEEK_NAME, SEEK_SOI, SEEK_EOI} t_carve_phase;

    localparam logic [63:0] OFS_MAX  = {64{1'b1}} >> (64 - OFFSET_BITS);
    localparam logic [63:0] U32_MAX  = 64'hFFFF_FFFF;
    localparam logic [7:0]  LOWER_A  = 8'h61;
    localparam logic [7:0]  LOWER_Z  = 8'h7A;
    localparam logic [7:0]  CASE_BIT = 8'h20;

    logic [15:0]  last_two;
    t_carve_phase phase;
    logic [63:0]  next_ofs;
    logic [63:0]  nul_next;
    logic [63:0]  name_lo;
    logic [63:0]  name_hi;
    logic [63:0]  soi_at;
    logic         sat_seen;
    t_out         expected_images[$];
    int           mismatch_count = 0;
    int           pending_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    function automatic void clear_scan();
        last_two = '0;
        phase    = SEEK_NAME;
        next_ofs = '0;
        nul_next = '0;
        name_lo  = '0;
        name_hi  = '0;
        soi_at   = '0;
        sat_seen = 1'b0;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= LOWER_A && c <= LOWER_Z) ? c - CASE_BIT : c;
    endfunction

    function automatic logic [31:0] fit32(input logic [63:0] v);
        return (v > U32_MAX) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Advances the scan by one byte; returns 1 when this byte closes an image.
    function automatic bit carve_byte(input t_in beat, output t_out span);
        logic [63:0] cur;
        logic [7:0]  older;
        logic [7:0]  prev;
        logic [7:0]  b;
        bit          hit;
        hit  = 1'b0;
        span = '0;
        if (beat.file_start)
            clear_scan();
        cur = next_ofs;
        if (cur >= OFS_MAX) begin
            next_ofs = OFS_MAX;
            sat_seen = 1'b1;
        end else begin
            next_ofs = cur + 64'd1;
        end
        older = last_two[15:8];
        prev  = last_two[7:0];
        b     = beat.data_byte;
        case (phase)
            SEEK_SOI: begin
                if (older == C_MARK && prev == C_SOI && b == C_MARK) begin
                    soi_at = (cur >= 64'd2) ? cur - 64'd2 : 64'd0;
                    phase  = SEEK_EOI;
                end
            end
            SEEK_EOI: begin
                // the closing FF may be the last FF of the start marker
                if (prev == C_MARK && b == C_EOI) begin
                    span.name_first       = fit32(name_lo);
                    span.name_last        = fit32(name_hi);
                    span.image_first      = fit32(soi_at);
                    span.image_last       = fit32(cur);
                    span.offset_saturated = sat_seen || name_lo > U32_MAX
                        || name_hi > U32_MAX || soi_at > U32_MAX || cur > U32_MAX;
                    hit   = 1'b1;
                    phase = SEEK_NAME;
                end
            end
            default: begin
                if (to_upper(b) == C_G_UP && to_upper(prev) == C_P_UP
                        && to_upper(older) == C_J_UP) begin
                    name_lo = nul_next;
                    name_hi = cur;
                    phase   = SEEK_SOI;
                end
            end
        endcase
        if (b == C_NUL)
            nul_next = (cur >= OFS_MAX) ? cur : cur + 64'd1;
        last_two = {prev, b};
        return hit;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        t_out fresh;
        if (!i_rst_n) begin
            clear_scan();
            expected_images.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_images.size() == 0) begin
                    $error("image span reported with none expected");
                    mismatch_count++;
                end else begin
                    want = expected_images.pop_front();
                    check_field("name_first", want.name_first, i_out_data.name_first);
                    check_field("name_last", want.name_last, i_out_data.name_last);
                    check_field("image_first", want.image_first, i_out_data.image_first);
                    check_field("image_last", want.image_last, i_out_data.image_last);
                    check_field("offset_saturated", {31'b0, want.offset_saturated},
                                {31'b0, i_out_data.offset_saturated});
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (carve_byte(i_in_data, fresh))
                    expected_images.push_back(fresh);
            end
        end
        pending_count = expected_images.size();
    end

endmodule

[tb/jpeg_carver_byte_scanner_test.sv]
`timescale 1ns / 1ps
// Top of the byte scanner testbench: clock, reset, byte stream and result back-pressure.
// Depends on jcbs_pkg, jpeg_carver_byte_scanner and jpeg_carver_byte_scanner_check.
module jpeg_carver_byte_scanner_test;
    import jcbs_pkg::*;

    localparam int OFS_W        = 32;
    localparam int RANDOM_BYTES = 1300;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 3000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_data;
    logic out_valid;
    logic out_stall;
    t_out out_data;
    int   mismatches;
    int   pending;

    int   bytes_sent;
    bit   tx_calm;
    bit   rx_calm;
    int   hold_reqs;
    logic rx_took;
    int   idle_cycles;

    jpeg_carver_byte_scanner #(
        .OFFSET_BITS(OFS_W)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_stall(in_stall),
        .i_data(in_data),
        .o_valid(out_valid),
        .i_stall(out_stall),
        .o_data(out_data)
    );

    jpeg_carver_byte_scanner_check #(
        .OFFSET_BITS(OFS_W)
    ) u_check (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .i_in_stall(in_stall),
        .i_in_data(in_data),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_data(out_data),
        .o_mismatches(mismatches),
        .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        rx_took <= out_valid && !out_stall;
    end

    // Result side: after each beat, stall for a drawn number of cycles; a hold
    // request stalls for a long stretch so the scanner backs up into its input.
    initial begin : receiver
        int stall_left;
        int seen_holds;
        stall_left = 0;
        seen_holds = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (seen_holds != hold_reqs) begin
                seen_holds = hold_reqs;
                stall_left = HOLD_CYCLES;
            end else if (rx_took === 1'b1) begin
                stall_left = rx_calm ? 0 : int'($urandom_range(0, 15));
            end
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("jpeg_carver_byte_scanner_test: done, errors");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // leaving valid up so a back-to-back byte needs only one assignment.
    task automatic feed_byte(input logic [7:0] b, input logic fs);
        int gap;
        gap = tx_calm ? 0 : int'($urandom_range(0, 15));
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.data_byte  <= b;
        in_data.file_start <= fs;
        in_valid           <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] pick_case(input logic [7:0] up, input logic [7:0] lo);
        return $urandom_range(0, 1) ? up : lo;
    endfunction

    // Weighted toward marker and name bytes so partial matches show up often.
    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 9))
            0: return C_NUL;
            1: return C_MARK;
            2: return C_SOI;
            3: return C_EOI;
            4: return pick_case(C_J_UP, C_J_LO);
            5: return pick_case(C_P_UP, C_P_LO);
            6: return pick_case(C_G_UP, C_G_LO);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_filler(input int n);
        repeat (n) feed_byte(any_byte(), $urandom_range(0, 59) == 0);
    endtask

    task automatic send_name(input bit broken);
        if ($urandom_range(0, 3) != 0)
            feed_byte(C_NUL, 1'b0);
        repeat ($urandom_range(0, 4)) feed_byte(8'($urandom_range(1, 255)), 1'b0);
        feed_byte(pick_case(C_J_UP, C_J_LO), 1'b0);
        feed_byte(pick_case(C_P_UP, C_P_LO), 1'b0);
        feed_byte(broken ? any_byte() : pick_case(C_G_UP, C_G_LO), 1'b0);
    endtask

    task automatic send_image(input bit finished);
        feed_byte(C_MARK, 1'b0);
        feed_byte(C_SOI, 1'b0);
        feed_byte(C_MARK, 1'b0);
        repeat ($urandom_range(0, 12)) feed_byte(any_byte(), 1'b0);
        if (finished) begin
            feed_byte(C_MARK, 1'b0);
            feed_byte(C_EOI, 1'b0);
        end
    endtask

    task automatic send_file();
        feed_byte(any_byte(), 1'b1);
        repeat ($urandom_range(1, 3)) begin
            send_filler($urandom_range(0, 6));
            case ($urandom_range(0, 9))
                7: send_name(1'b1);
                8: begin
                    // start marker cut short
                    send_name(1'b0);
                    feed_byte(C_MARK, 1'b0);
                    feed_byte(C_SOI, 1'b0);
                    feed_byte(any_byte(), 1'b0);
                end
                9: begin
                    send_name(1'b0);
                    send_image(1'b0);
                end
                default: begin
                    send_name(1'b0);
                    send_filler($urandom_range(0, 4));
                    send_image(1'b1);
                end
            endcase
        end
    endtask

    initial begin : stimulus
        bit         pressed;
        logic [7:0] script [28];
        pressed     = 1'b0;
        // restart on a G right after J P, lowercase name with no NUL before it,
        // end marker sharing the start marker's FF, NUL inside an image,
        // and an image left open when the next file starts on a D9
        script = '{C_J_UP, C_P_UP, C_G_UP, C_J_LO, C_P_LO, C_G_LO,
                   C_MARK, C_SOI, C_MARK, C_EOI,
                   C_NUL, 8'h78, C_J_UP, C_P_LO, C_G_UP,
                   C_MARK, C_SOI, C_MARK, C_NUL, C_MARK, C_EOI,
                   C_J_UP, C_P_UP, C_G_UP, C_MARK, C_SOI, C_MARK, C_EOI};
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        hold_reqs   = 0;
        bytes_sent  = 0;
        idle_cycles = 0;
        rx_took     = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 28; i++)
            feed_byte(script[i], i == 0 || i == 2 || i == 27);

        while (bytes_sent < 28 + RANDOM_BYTES) begin
            if (!pressed && bytes_sent > 600) begin
                pressed = 1'b1;
                hold_reqs <= hold_reqs + 1;
                tx_calm = 1'b1;
                repeat (4) begin
                    send_name(1'b0);
                    send_image(1'b1);
                end
            end
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm <= ($urandom_range(0, 4) == 0);
            send_file();
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("jpeg_carver_byte_scanner_test: done, clean");
        else
            $display("jpeg_carver_byte_scanner_test: done, errors");
        $finish;
    end

endmodule
